[rtl/assert_macros.svh]
// Assertion macros used by the port checker file.
// Include guard keeps repeated includes harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication under clock and active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/gle_pkg.sv]
// Package for the glyph layout engine: beat types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package gle_pkg;
	localparam int GlyphSlots = 128;
	localparam int KernSlots  = 256;

	localparam logic [1:0] OP_GLYPH = 2'd0;
	localparam logic [1:0] OP_KERN  = 2'd1;
	localparam logic [1:0] OP_CHAR  = 2'd2;
	localparam logic [1:0] OP_HOME  = 2'd3;

	localparam logic [15:0] CODE_NEWLINE = 16'd10;
	localparam logic [15:0] CODE_TAB     = 16'd9;

	localparam logic [2:0] REG_BASELINE = 3'd0;
	localparam logic [2:0] REG_LINE_H   = 3'd1;
	localparam logic [2:0] REG_TAB      = 3'd2;
	localparam logic [2:0] REG_ORG_X    = 3'd3;
	localparam logic [2:0] REG_ORG_Y    = 3'd4;
	localparam logic [2:0] REG_COLOR    = 3'd5;

	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        code;
		logic [15:0]        next_code;
		logic [15:0]        tex_x;
		logic [15:0]        tex_y;
		logic [15:0]        glyph_width;
		logic [15:0]        glyph_height;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic [15:0]        advance;
		logic signed [15:0] kern_amount;
	} in_beat_t;

	typedef struct packed {
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        vertex_color;
		logic               last;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GSCAN, ST_KSCAN, ST_DECIDE, ST_GREAD, ST_TAB,
		ST_EMIT0, ST_EMIT1, ST_STEP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;     // capture input beat, clear scan state
		logic gscan;       // advance glyph table scan
		logic kscan;       // advance kern table scan
		logic gwrite;      // store glyph
		logic kwrite;      // store kern pair
		logic home;
		logic newline;
		logic tab_start;
		logic tab_step;
		logic gread;       // read matched glyph entry
		logic emit0;       // load top-left corner into output reg
		logic emit1;       // load bottom-right corner
		logic advance;     // cursor_x += step + kern amount
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0]  op;
		logic        is_newline;
		logic        is_tab;
		logic        gscan_done;
		logic        kscan_done;
		logic        gfound;
		logic        gfull;
		logic        kfound;
		logic        kfull;
		logic        tab_done;
		logic        out_busy;
	} status_t;
endpackage

[rtl/gle_ctrl.sv]
// Controller state machine of the glyph layout engine.
// Depends on gle_pkg.
`timescale 1ns / 1ps
module gle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	output logic             in_ready,
	input  gle_pkg::status_t st,
	output gle_pkg::cmd_t    cmd
);
	import gle_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load_in = 1'b1;
					state_d = ST_GSCAN;
				end
			end
			ST_GSCAN: begin
				if (st.op == OP_HOME) begin
					cmd.home = 1'b1;
					state_d = ST_IDLE;
				end else if (st.op == OP_CHAR && st.is_newline) begin
					cmd.newline = 1'b1;
					state_d = ST_IDLE;
				end else if (st.op == OP_CHAR && st.is_tab) begin
					cmd.tab_start = 1'b1;
					state_d = ST_TAB;
				end else if (st.op == OP_KERN) begin
					state_d = ST_KSCAN;
				end else if (st.gscan_done) begin
					state_d = (st.op == OP_CHAR) ? ST_KSCAN : ST_DECIDE;
				end else begin
					cmd.gscan = 1'b1;
				end
			end
			ST_KSCAN: begin
				if (st.kscan_done) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.kscan = 1'b1;
				end
			end
			ST_DECIDE: begin
				case (st.op)
					OP_GLYPH: begin
						cmd.gwrite = !st.gfound && !st.gfull;
						state_d = ST_IDLE;
					end
					OP_KERN: begin
						cmd.kwrite = !st.kfound && !st.kfull;
						state_d = ST_IDLE;
					end
					default: begin
						if (st.gfound) begin
							cmd.gread = 1'b1;
							state_d = ST_GREAD;
						end else begin
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_GREAD: state_d = ST_EMIT0;
			ST_EMIT0: begin
				if (!st.out_busy) begin
					cmd.emit0 = 1'b1;
					state_d = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				if (!st.out_busy) begin
					cmd.emit1 = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.advance = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TAB: begin
				if (st.tab_done) begin
					state_d = ST_IDLE;
				end else begin
					cmd.tab_step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/gle_datapath.sv]
// Datapath of the glyph layout engine: tables, scans, cursor, tab divider,
// output register. Depends on gle_pkg.
`timescale 1ns / 1ps
module gle_datapath #(
	parameter int GLYPH_SLOTS = gle_pkg::GlyphSlots,
	parameter int KERN_SLOTS  = gle_pkg::KernSlots
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gle_pkg::in_beat_t   in_beat,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  gle_pkg::cmd_t       cmd,
	output gle_pkg::status_t    st,
	output logic                out_valid,
	input  logic                out_ready,
	output gle_pkg::out_beat_t  out_beat
);
	import gle_pkg::*;

	localparam int GW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int KW = (KERN_SLOTS > 1) ? $clog2(KERN_SLOTS) : 1;
	localparam int GC = $clog2(GLYPH_SLOTS + 1);
	localparam int KC = $clog2(KERN_SLOTS + 1);

	// config
	logic [15:0] baseline_q, line_h_q, tab_q;
	logic [31:0] org_x_q, org_y_q, color_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
			line_h_q   <= 16'd16;
			tab_q      <= 16'd100;
			org_x_q    <= '0;
			org_y_q    <= '0;
			color_q    <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASELINE: baseline_q <= cfg_data[15:0];
				REG_LINE_H:   line_h_q   <= cfg_data[15:0];
				REG_TAB:      tab_q      <= cfg_data[15:0];
				REG_ORG_X:    org_x_q    <= cfg_data;
				REG_ORG_Y:    org_y_q    <= cfg_data;
				REG_COLOR:    color_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	in_beat_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= in_beat;
	end

	// memories; entries below the fill count are the valid ones
	logic [15:0] gkey_mem [GLYPH_SLOTS];
	logic [63:0] gtex_mem [GLYPH_SLOTS];
	logic [63:0] gvert_mem [GLYPH_SLOTS];
	logic [15:0] gstep_mem [GLYPH_SLOTS];
	logic [31:0] kkey_mem [KERN_SLOTS];
	logic [15:0] kval_mem [KERN_SLOTS];

	logic [GC-1:0] gfill_q, gidx_q;
	logic [KC-1:0] kfill_q, kidx_q;
	logic [GW-1:0] ghit_q;
	logic          gfound_q, kfound_q;
	logic [15:0]   gkey_rd_q, kval_q;
	logic [31:0]   kkey_rd_q;
	logic          grd_v_q, krd_v_q;
	logic [GW-1:0] gwa;
	logic [KW-1:0] kwa;
	logic [15:0]   ydiff;

	assign gwa   = gfill_q[GW-1:0];
	assign kwa   = kfill_q[KW-1:0];
	assign ydiff = item_q.y_offset - baseline_q;

	always_ff @(posedge clk) begin
		if (cmd.gwrite) begin
			gkey_mem[gwa]  <= item_q.code;
			gtex_mem[gwa]  <= {item_q.tex_y + item_q.glyph_height,
				item_q.tex_x + item_q.glyph_width, item_q.tex_y, item_q.tex_x};
			gvert_mem[gwa] <= {ydiff + item_q.glyph_height,
				item_q.x_offset + item_q.glyph_width, ydiff, item_q.x_offset};
			gstep_mem[gwa] <= item_q.advance;
		end
		if (cmd.kwrite) begin
			kkey_mem[kwa] <= {item_q.code, item_q.next_code};
			kval_mem[kwa] <= item_q.kern_amount;
		end
	end

	// scans: one read per cycle, compare on registered data the next cycle
	logic [63:0] tex_q, vert_q;
	logic [15:0] step_q;
	always_ff @(posedge clk) begin
		gkey_rd_q <= gkey_mem[gidx_q[GW-1:0]];
		kkey_rd_q <= kkey_mem[kidx_q[KW-1:0]];
		kval_q    <= kval_mem[kidx_q[KW-1:0]];
		if (cmd.gread) begin
			tex_q  <= gtex_mem[ghit_q];
			vert_q <= gvert_mem[ghit_q];
			step_q <= gstep_mem[ghit_q];
		end
	end

	logic [15:0] kamt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gfill_q  <= '0;
			kfill_q  <= '0;
			gidx_q   <= '0;
			kidx_q   <= '0;
			grd_v_q  <= 1'b0;
			krd_v_q  <= 1'b0;
			gfound_q <= 1'b0;
			kfound_q <= 1'b0;
			ghit_q   <= '0;
			kamt_q   <= '0;
		end else begin
			if (cmd.load_in) begin
				gidx_q   <= '0;
				kidx_q   <= '0;
				grd_v_q  <= 1'b0;
				krd_v_q  <= 1'b0;
				gfound_q <= 1'b0;
				kfound_q <= 1'b0;
				kamt_q   <= '0;
			end
			if (cmd.gscan) begin
				grd_v_q <= (gidx_q < gfill_q);
				if (gidx_q < gfill_q) gidx_q <= gidx_q + 1'b1;
				if (grd_v_q && !gfound_q && gkey_rd_q == item_q.code) begin
					gfound_q <= 1'b1;
					ghit_q   <= GW'(gidx_q - 1'b1);
				end
			end
			if (cmd.kscan) begin
				krd_v_q <= (kidx_q < kfill_q);
				if (kidx_q < kfill_q) kidx_q <= kidx_q + 1'b1;
				if (krd_v_q && !kfound_q &&
					kkey_rd_q == {item_q.code, item_q.next_code}) begin
					kfound_q <= 1'b1;
					kamt_q   <= kval_q;
				end
			end
			if (cmd.gwrite) gfill_q <= gfill_q + 1'b1;
			if (cmd.kwrite) kfill_q <= kfill_q + 1'b1;
		end
	end

	// done once index reached fill and last read compared
	assign st.gscan_done = (gidx_q >= gfill_q) && !grd_v_q;
	assign st.kscan_done = (kidx_q >= kfill_q) && !krd_v_q;
	assign st.gfound     = gfound_q;
	assign st.kfound     = kfound_q;
	assign st.gfull      = (gfill_q == GC'(GLYPH_SLOTS));
	assign st.kfull      = (kfill_q == KC'(KERN_SLOTS));
	assign st.op         = item_q.op;
	assign st.is_newline = (item_q.code == CODE_NEWLINE);
	assign st.is_tab     = (item_q.code == CODE_TAB);

	// tab: restoring divide of |x| by tab_size, one quotient bit a cycle
	logic [31:0] mag_q, quo_q;
	logic [32:0] rem_q, rem_sh;
	logic [5:0]  tcnt_q;
	logic        tneg_q, tbusy_q;
	logic [31:0] cur_x_q, cur_y_q;
	logic signed [32:0] tq_s;
	logic [47:0] prod;
	assign rem_sh = {rem_q[31:0], mag_q[31]};
	assign st.tab_done = !tbusy_q;
	assign tq_s = tneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbusy_q <= 1'b0;
			tcnt_q  <= '0;
			tneg_q  <= 1'b0;
			mag_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
		end else if (cmd.tab_start) begin
			tbusy_q <= (tab_q != '0);
			tneg_q  <= cur_x_q[31];
			mag_q   <= cur_x_q[31] ? (~cur_x_q + 1'b1) : cur_x_q;
			quo_q   <= '0;
			rem_q   <= '0;
			tcnt_q  <= 6'd0;
		end else if (cmd.tab_step) begin
			if (tcnt_q < 6'd32) begin
				mag_q <= {mag_q[30:0], 1'b0};
				if (rem_sh >= {17'd0, tab_q}) begin
					rem_q <= rem_sh - {17'd0, tab_q};
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				tcnt_q <= tcnt_q + 1'b1;
			end else begin
				tbusy_q <= 1'b0;
			end
		end
	end
	assign prod = 48'(tq_s[31:0] + 32'd1) * 48'(tab_q);

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			if (cmd.home) begin
				cur_x_q <= org_x_q;
				cur_y_q <= org_y_q;
			end
			if (cmd.newline) begin
				cur_x_q <= org_x_q;
				cur_y_q <= cur_y_q + {16'd0, line_h_q};
			end
			if (cmd.tab_step && tcnt_q == 6'd32) cur_x_q <= prod[31:0];
			if (cmd.advance)
				cur_x_q <= cur_x_q + {16'd0, step_q} + {{16{kamt_q[15]}}, kamt_q};
		end
	end

	// output register
	logic out_v_q;
	out_beat_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit0 || cmd.emit1) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.emit0) begin
			out_q <= '{tex_u: tex_q[15:0], tex_v: tex_q[31:16],
				pos_x: cur_x_q[15:0] + vert_q[15:0],
				pos_y: cur_y_q[15:0] + vert_q[31:16],
				vertex_color: color_q, last: 1'b0};
		end else if (cmd.emit1) begin
			out_q <= '{tex_u: tex_q[47:32], tex_v: tex_q[63:48],
				pos_x: cur_x_q[15:0] + vert_q[47:32],
				pos_y: cur_y_q[15:0] + vert_q[63:48],
				vertex_color: color_q, last: 1'b1};
		end
	end
	assign st.out_busy = out_v_q && !out_ready;
	assign out_valid   = out_v_q;
	assign out_beat    = out_q;
endmodule

[rtl/glyph_layout_engine.sv]
// Glyph layout engine: one item at a time, in_ready is high only while idle.
// Glyph load scans the glyph table, kerning load the kern table (linear table scan,
// one memory read a cycle). A character scans both tables and, if its glyph is
// known, emits two output beats and can stall on the output; unknown ones emit none.
// Tab uses bit-serial division; newline and home only move the cursor.
// Reset (arst_n low) empties both tables and clears the cursor at once.
`timescale 1ns / 1ps
module glyph_layout_engine #(
	parameter int GLYPH_SLOTS = gle_pkg::GlyphSlots,
	parameter int KERN_SLOTS  = gle_pkg::KernSlots
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gle_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output gle_pkg::out_beat_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import gle_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	gle_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && in_ready),
		.in_ready(in_ready), .st(st), .cmd(cmd)
	);

	gle_datapath #(.GLYPH_SLOTS(GLYPH_SLOTS), .KERN_SLOTS(KERN_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .st(st), .out_valid(out_valid), .out_ready(out_ready),
		.out_beat(out_data)
	);
endmodule

[rtl/gle_checker.sv]
// Port-level checker for the glyph layout engine, bound to the top level.
// Depends on gle_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gle_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input gle_pkg::out_beat_t out_data
);
	import gle_pkg::*;

	// output beat held while stalled
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// a presented result beat is fully defined
	`ASSERT_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown(out_data))
	// taking a first corner leaves the engine busy, in_ready low
	`ASSERT_NEXT(a_pair, clk, arst_n, out_valid && out_ready && !out_data.last, !in_ready)
	// input acceptance ends readiness for the next cycle
	`ASSERT_NEXT(a_one, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind glyph_layout_engine gle_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
